/* rtl/bes_pkg.sv */
// Shared constants, types and the arctangent table for the elevation solver.
// No dependencies; imported by every module of the block.
package bes_pkg;

    localparam int CordicIterDef = 16;
    localparam int CordicMax     = 32;
    localparam int ValW          = 64;  // CORDIC x/y datapath width (signed)
    localparam int ZW            = 28;  // angle accumulator, degrees * 2^20
    localparam int DiscW         = 96;  // discriminant width (unsigned)
    localparam int RootW         = 48;  // square-root result width
    localparam int ElevW         = 18;
    localparam int ElevLimit     = 92160;
    localparam int UnreachAngle  = -1024;

    localparam logic [15:0] GravityRst  = 16'd9800;
    localparam logic [15:0] DeadZoneRst = 16'd65535;
    localparam logic [15:0] SlopeRst    = 16'd0;

    localparam logic [1:0] RegGravity  = 2'd0;
    localparam logic [1:0] RegDeadZone = 2'd1;
    localparam logic [1:0] RegSlope    = 2'd2;

    // Per-item sideband carried down the pipeline
    typedef struct packed {
        logic ok;     // a real solution exists
        logic zero_g; // straight-line aim
    } t_flags;

    // atan(2^-i) in degrees * 2^20, rounded
    function automatic logic signed [ZW-1:0] atan_tab(input int idx);
        logic signed [ZW-1:0] t;
        begin
            case (idx)
                0: t = 28'sd47185920;  1: t = 28'sd27855475;
                2: t = 28'sd14718068;  3: t = 28'sd7471121;
                4: t = 28'sd3750058;   5: t = 28'sd1876857;
                6: t = 28'sd938658;    7: t = 28'sd469357;
                8: t = 28'sd234682;    9: t = 28'sd117342;
                10: t = 28'sd58671;    11: t = 28'sd29335;
                12: t = 28'sd14668;    13: t = 28'sd7334;
                14: t = 28'sd3667;     15: t = 28'sd1833;
                16: t = 28'sd917;      17: t = 28'sd458;
                18: t = 28'sd229;      19: t = 28'sd115;
                20: t = 28'sd57;       21: t = 28'sd29;
                22: t = 28'sd14;       23: t = 28'sd7;
                24: t = 28'sd4;        25: t = 28'sd2;
                26: t = 28'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

/* rtl/bes_sqrt_cell.sv */
// One restoring square-root cell: decides one result bit per cycle-stage.
// Depends on bes_pkg.
module bes_sqrt_cell import bes_pkg::*; #(
    parameter int BIT = 47
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [DiscW-1:0]        i_rem,
    input  logic [RootW-1:0]        i_root,
    input  logic [ValW-1:0]         i_bv,
    input  logic [ValW-1:0]         i_gd,
    input  t_flags                  i_flags,
    output logic [DiscW-1:0]        o_rem,
    output logic [RootW-1:0]        o_root,
    output logic [ValW-1:0]         o_bv,
    output logic [ValW-1:0]         o_gd,
    output t_flags                  o_flags
);
    // (r + b)^2 - r^2 = 2rb + b^2 ; compare against remaining value
    logic [DiscW-1:0] w_try;
    logic             w_take;

    assign w_try  = ({{(DiscW-RootW){1'b0}}, i_root} << (BIT + 1))
                  + ({{(DiscW-1){1'b0}}, 1'b1} << (2 * BIT));
    assign w_take = (w_try <= i_rem);

    // Advance one bit position
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem   <= w_take ? i_rem - w_try : i_rem;
            o_root  <= w_take ? (i_root | (RootW'(1) << BIT)) : i_root;
            o_bv    <= i_bv;
            o_gd    <= i_gd;
            o_flags <= i_flags;
        end
    end
endmodule

/* rtl/bes_cordic_cell.sv */
// One CORDIC vectoring cell for two independent vectors (both roots).
// Depends on bes_pkg.
module bes_cordic_cell import bes_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [ValW-1:0] i_x1,
    input  logic signed [ValW-1:0] i_y1,
    input  logic signed [ZW-1:0]   i_z1,
    input  logic signed [ValW-1:0] i_x2,
    input  logic signed [ValW-1:0] i_y2,
    input  logic signed [ZW-1:0]   i_z2,
    input  t_flags                 i_flags,
    output logic signed [ValW-1:0] o_x1,
    output logic signed [ValW-1:0] o_y1,
    output logic signed [ZW-1:0]   o_z1,
    output logic signed [ValW-1:0] o_x2,
    output logic signed [ValW-1:0] o_y2,
    output logic signed [ZW-1:0]   o_z2,
    output t_flags                 o_flags
);
    localparam logic signed [ZW-1:0] Ang = atan_tab(STEP);

    logic signed [ValW-1:0] w_xs1, w_ys1, w_xs2, w_ys2;
    assign w_xs1 = i_x1 >>> STEP;
    assign w_ys1 = i_y1 >>> STEP;
    assign w_xs2 = i_x2 >>> STEP;
    assign w_ys2 = i_y2 >>> STEP;

    // Rotate each vector toward the x axis
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y1[ValW-1]) begin
                o_x1 <= i_x1 + w_ys1; o_y1 <= i_y1 - w_xs1; o_z1 <= i_z1 + Ang;
            end else begin
                o_x1 <= i_x1 - w_ys1; o_y1 <= i_y1 + w_xs1; o_z1 <= i_z1 - Ang;
            end
            if (!i_y2[ValW-1]) begin
                o_x2 <= i_x2 + w_ys2; o_y2 <= i_y2 - w_xs2; o_z2 <= i_z2 + Ang;
            end else begin
                o_x2 <= i_x2 - w_ys2; o_y2 <= i_y2 + w_xs2; o_z2 <= i_z2 - Ang;
            end
            o_flags <= i_flags;
        end
    end
endmodule

/* rtl/ballistic_elevation_solver_top.sv */
// Top level of the elevation solver: front end, sqrt and CORDIC cell chains, output.
// Depends on bes_pkg, bes_sqrt_cell and bes_cordic_cell.
//
// Usage:
//   Input channel (i_valid/o_ready) carries muzzle speed, range and target
//   height; output channel (o_valid/i_ready) carries elevation and the
//   reachable flag. Registers are to be written via i_cfg_we/i_cfg_index/
//   i_cfg_data only while the block is idle, which it does not enforce;
//   unknown indexes are ignored. The block is one pipeline: 6 front-end
//   stages (height correction, products, 24x24 partial products, their
//   sums and the discriminant), 48 square-root cells, CORDIC_ITERATIONS
//   arctangent cells (at most 32) and 2 output stages. A new item is taken
//   every cycle unless the output stalls. The whole pipeline advances
//   together; when the receiver stalls with a result waiting, the pipeline
//   holds and o_ready drops only if the output stage is full and not taken,
//   so the last stage acts as the output register.
//   Reset clears all valid bits and loads the register defaults; data
//   registers are not cleared.
module ballistic_elevation_solver_top import bes_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CordicIterDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [15:0]             i_muzzle_speed,
    input  logic [15:0]             i_target_range,
    input  logic signed [15:0]      i_target_height,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ElevW-1:0] o_elevation,
    output logic                    o_reachable,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);
    localparam int NIt   = (CORDIC_ITERATIONS > CordicMax) ? CordicMax : CORDIC_ITERATIONS;
    localparam int NFe   = 6;
    localparam int NSq   = RootW;
    localparam int NTot  = NFe + NSq + NIt + 2;

    // Sum the four 24x24 partial products of a 48x48 product
    function automatic logic [DiscW-1:0] join_pp(input logic [47:0] ll,
                                                 input logic [47:0] lh,
                                                 input logic [47:0] hl,
                                                 input logic [47:0] hh);
        return (DiscW'(hh) << 48) + (DiscW'(lh) << 24) + (DiscW'(hl) << 24) + DiscW'(ll);
    endfunction

    logic [15:0]        r_gravity, r_dead_zone;
    logic signed [15:0] r_slope;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= GravityRst;
            r_dead_zone <= DeadZoneRst;
            r_slope     <= SlopeRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegGravity:  r_gravity   <= i_cfg_data;
                RegDeadZone: r_dead_zone <= i_cfg_data;
                RegSlope:    r_slope     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: stall all stages when the output is held
    logic             w_adv;
    logic [NTot-1:0]  r_vld;
    assign w_adv   = !r_vld[NTot-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[NTot-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NTot-2:0], i_valid};
        end
    end

    // Stage 1: height correction product
    logic [15:0]        r1_v, r1_d;
    logic signed [15:0] r1_h;
    logic signed [33:0] r1_corr;
    logic               r1_app;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_v    <= i_muzzle_speed;
            r1_d    <= i_target_range;
            r1_h    <= i_target_height;
            r1_app  <= i_target_range > r_dead_zone;
            r1_corr <= $signed({1'b0, i_target_range - r_dead_zone}) * r_slope;
        end
    end

    // Stage 2: adjusted height, v^2, g*d
    logic signed [19:0] r2_h;
    logic [31:0]        r2_v2;
    logic [31:0]        r2_gd;
    logic [15:0]        r2_d;
    logic               r2_bad, r2_zg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_h   <= r1_app ? 20'(r1_h) + 20'(r1_corr >>> 15) : 20'(r1_h);
            r2_v2  <= r1_v * r1_v;
            r2_gd  <= r1_d * r_gravity;
            r2_d   <= r1_d;
            r2_bad <= (r1_v == 16'd0) || (r1_d == 16'd0);
            r2_zg  <= (r_gravity == 16'd0);
        end
    end

    // Stage 3: V = 15625 v^2, gd10, g*|h|*2^11
    logic [ValW-1:0]    r3_bv, r3_gd;
    logic [47:0]        r3_gh;
    logic signed [19:0] r3_h;
    logic [15:0]        r3_d;
    logic               r3_bad, r3_zg;
    logic [19:0]        w_habs;
    assign w_habs = r2_h[19] ? 20'(-r2_h) : 20'(r2_h);
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_bv  <= ValW'(r2_v2) * ValW'(15625);
            r3_gd  <= ValW'(r2_gd) << 10;
            r3_gh  <= (48'(w_habs) * 48'(r_gravity)) << 11;
            r3_h   <= r2_h;
            r3_d   <= r2_d;
            r3_bad <= r2_bad;
            r3_zg  <= r2_zg;
        end
    end

    // Stage 4a: 24x24 partial products of the three wide products
    logic [47:0]        r4p_t1 [4];
    logic [47:0]        r4p_t2 [4];
    logic [47:0]        r4p_t3 [4];
    logic [ValW-1:0]    r4p_bv, r4p_gd;
    logic signed [19:0] r4p_h;
    logic [15:0]        r4p_d;
    logic               r4p_bad, r4p_zg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4p_t1[0] <= 48'(r3_bv[23:0])  * 48'(r3_bv[23:0]);
            r4p_t1[1] <= 48'(r3_bv[23:0])  * 48'(r3_bv[47:24]);
            r4p_t1[2] <= 48'(r3_bv[47:24]) * 48'(r3_bv[23:0]);
            r4p_t1[3] <= 48'(r3_bv[47:24]) * 48'(r3_bv[47:24]);
            r4p_t2[0] <= 48'(r3_gd[23:0])  * 48'(r3_gd[23:0]);
            r4p_t2[1] <= 48'(r3_gd[23:0])  * 48'(r3_gd[47:24]);
            r4p_t2[2] <= 48'(r3_gd[47:24]) * 48'(r3_gd[23:0]);
            r4p_t2[3] <= 48'(r3_gd[47:24]) * 48'(r3_gd[47:24]);
            r4p_t3[0] <= 48'(r3_gh[23:0])  * 48'(r3_bv[23:0]);
            r4p_t3[1] <= 48'(r3_gh[23:0])  * 48'(r3_bv[47:24]);
            r4p_t3[2] <= 48'(r3_gh[47:24]) * 48'(r3_bv[23:0]);
            r4p_t3[3] <= 48'(r3_gh[47:24]) * 48'(r3_bv[47:24]);
            r4p_bv    <= r3_bv;
            r4p_gd    <= r3_gd;
            r4p_h     <= r3_h;
            r4p_d     <= r3_d;
            r4p_bad   <= r3_bad;
            r4p_zg    <= r3_zg;
        end
    end

    // Stage 4b: sum the partial products into the three wide products
    logic [DiscW-1:0]   r4_t1, r4_t2, r4_t3;
    logic [ValW-1:0]    r4_bv, r4_gd;
    logic signed [19:0] r4_h;
    logic [15:0]        r4_d;
    logic               r4_bad, r4_zg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_t1  <= join_pp(r4p_t1[0], r4p_t1[1], r4p_t1[2], r4p_t1[3]);
            r4_t2  <= join_pp(r4p_t2[0], r4p_t2[1], r4p_t2[2], r4p_t2[3]);
            r4_t3  <= join_pp(r4p_t3[0], r4p_t3[1], r4p_t3[2], r4p_t3[3]);
            r4_bv  <= r4p_bv;
            r4_gd  <= r4p_gd;
            r4_h   <= r4p_h;
            r4_d   <= r4p_d;
            r4_bad <= r4p_bad;
            r4_zg  <= r4p_zg;
        end
    end

    // Stage 5: discriminant and sign check; zero gravity swaps in (d, h)
    logic [DiscW-1:0] w_pos, w_neg;
    logic [DiscW-1:0] r5_disc;
    logic [ValW-1:0]  r5_bv, r5_gd;
    t_flags           r5_fl;
    assign w_pos = r4_h[19] ? r4_t1 + r4_t3 : r4_t1;
    assign w_neg = r4_h[19] ? r4_t2 : r4_t2 + r4_t3;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_disc      <= r4_zg ? '0 : w_pos - w_neg;
            r5_bv        <= r4_zg ? ValW'(r4_h) : r4_bv;
            r5_gd        <= r4_zg ? ValW'(r4_d) : r4_gd;
            r5_fl.zero_g <= r4_zg;
            r5_fl.ok     <= !r4_bad && (r4_zg || (w_neg <= w_pos));
        end
    end

    // Square-root cell chain
    logic [DiscW-1:0] w_rem  [NSq+1];
    logic [RootW-1:0] w_root [NSq+1];
    logic [ValW-1:0]  w_sbv  [NSq+1];
    logic [ValW-1:0]  w_sgd  [NSq+1];
    t_flags           w_sfl  [NSq+1];
    assign w_rem[0]  = r5_disc;
    assign w_root[0] = '0;
    assign w_sbv[0]  = r5_bv;
    assign w_sgd[0]  = r5_gd;
    assign w_sfl[0]  = r5_fl;

    for (genvar k = 0; k < NSq; k++) begin : g_sq
        bes_sqrt_cell #(.BIT(NSq - 1 - k)) u_cell (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem(w_rem[k]), .i_root(w_root[k]), .i_bv(w_sbv[k]), .i_gd(w_sgd[k]),
            .i_flags(w_sfl[k]),
            .o_rem(w_rem[k+1]), .o_root(w_root[k+1]), .o_bv(w_sbv[k+1]),
            .o_gd(w_sgd[k+1]), .o_flags(w_sfl[k+1])
        );
    end

    // CORDIC cell chain on both roots
    logic signed [ValW-1:0] w_x1 [NIt+1], w_y1 [NIt+1], w_x2 [NIt+1], w_y2 [NIt+1];
    logic signed [ZW-1:0]   w_z1 [NIt+1], w_z2 [NIt+1];
    t_flags                 w_cfl [NIt+1];
    logic signed [ValW-1:0] w_s;
    assign w_s     = $signed(ValW'(w_root[NSq]));
    assign w_x1[0] = $signed(w_sgd[NSq]);
    assign w_x2[0] = $signed(w_sgd[NSq]);
    assign w_y1[0] = $signed(w_sbv[NSq]) + w_s;
    assign w_y2[0] = $signed(w_sbv[NSq]) - w_s;
    assign w_z1[0] = '0;
    assign w_z2[0] = '0;
    assign w_cfl[0] = w_sfl[NSq];

    for (genvar k = 0; k < NIt; k++) begin : g_cd
        bes_cordic_cell #(.STEP(k)) u_cell (
            .i_clk(i_clk), .i_en(w_adv),
            .i_x1(w_x1[k]), .i_y1(w_y1[k]), .i_z1(w_z1[k]),
            .i_x2(w_x2[k]), .i_y2(w_y2[k]), .i_z2(w_z2[k]), .i_flags(w_cfl[k]),
            .o_x1(w_x1[k+1]), .o_y1(w_y1[k+1]), .o_z1(w_z1[k+1]),
            .o_x2(w_x2[k+1]), .o_y2(w_y2[k+1]), .o_z2(w_z2[k+1]), .o_flags(w_cfl[k+1])
        );
    end

    // Select smaller-magnitude angle (tie keeps second root; zero gravity keeps the first)
    logic signed [ZW-1:0] w_z1f, w_z2f, w_a1, w_a2;
    logic signed [ZW-1:0] r6_z;
    t_flags               r6_fl;
    assign w_z1f = w_z1[NIt];
    assign w_z2f = w_z2[NIt];
    assign w_a1  = w_z1f[ZW-1] ? -w_z1f : w_z1f;
    assign w_a2  = w_z2f[ZW-1] ? -w_z2f : w_z2f;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_z  <= w_cfl[NIt].zero_g ? w_z1f : ((w_a1 < w_a2) ? w_z1f : w_z2f);
            r6_fl <= w_cfl[NIt];
        end
    end

    // Output register: round, clamp and unreachable code
    logic signed [ZW-1:0] w_e;
    assign w_e = (r6_z + ZW'(512)) >>> 10;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_reachable <= r6_fl.ok;
            if (!r6_fl.ok)
                o_elevation <= ElevW'(UnreachAngle);
            else if (w_e > ZW'(ElevLimit))
                o_elevation <= ElevW'(ElevLimit);
            else if (w_e < -ZW'(ElevLimit))
                o_elevation <= -ElevW'(ElevLimit);
            else
                o_elevation <= ElevW'(w_e);
        end
    end
endmodule
